// ===== rtl/core/nst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nst_pkg;

    localparam int NAME_BYTES = 16;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int COUNT_W    = 16;

    localparam logic [1:0] FN_OPEN   = 2'd0;
    localparam logic [1:0] FN_WAIT   = 2'd1;
    localparam logic [1:0] FN_POST   = 2'd2;
    localparam logic [1:0] FN_UNLINK = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL  = 3'd3;
    localparam logic [2:0] ST_QUEUE_EMPTY = 3'd4;
    localparam logic [2:0] ST_TOO_LONG    = 3'd5;

    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_EXEC,
        S_WAKE,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/nst_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface nst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [14:0] init_value;
    logic [4:0]  sem_handle;
    logic [5:0]  task_id;

    modport source (
        output valid, func, name_low, name_high, init_value, sem_handle, task_id,
        input  ready
    );
    modport sink (
        input  valid, func, name_low, name_high, init_value, sem_handle, task_id,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/nst_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface nst_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] handle_out;
    logic       must_block;
    logic       woken_valid;
    logic [5:0] woken_task;

    modport source (
        output valid, status, handle_out, must_block, woken_valid, woken_task,
        input  ready
    );
    modport sink (
        input  valid, status, handle_out, must_block, woken_valid, woken_task,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/nst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/nst_canon.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nst_canon
    import nst_pkg::*;
(
    input  wire logic [63:0]       name_low,
    input  wire logic [63:0]       name_high,
    output logic      [NAME_W-1:0] name_canon,
    output logic                   too_long
);

    logic [NAME_W-1:0]     raw;
    logic [NAME_BYTES-1:0] zero;
    logic [NAME_BYTES-1:0] keep;

    assign raw = {name_high, name_low};

    // a byte survives only if no zero byte sits at or below it
    for (genvar g = 0; g < NAME_BYTES; g++)
    begin : g_byte
        assign zero[g] = (raw[8*g +: 8] == 8'd0);
        assign keep[g] = ~|zero[g:0];
        assign name_canon[8*g +: 8] = keep[g] ? raw[8*g +: 8] : 8'd0;
    end

    assign too_long = ~|zero;

endmodule
`default_nettype wire

// ===== rtl/core/named_semaphore_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Table of SLOTS named counting semaphores, each with a wait queue of
// QUEUE_DEPTH-1 task ids. One request beat is taken at a time; ready is high
// only while the sequencer is idle. Open and unlink walk the name store one
// slot per cycle through a single 128-bit comparator, stopping early on a
// hit. Wait and post read the slot state and then update it; a post that
// dequeues a waiter also passes a wake state that takes its task id from
// the wait store. A finished response sits in an output register, so the
// next request is taken while it waits. No clearing pass after reset: only
// the state, the slot used bits and the valid flags are reset.
module named_semaphore_table
    import nst_pkg::*;
#(
    parameter int SLOTS       = 32,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    nst_req_if.sink    req,
    nst_rsp_if.source  rsp
);

    localparam int IW  = $clog2(SLOTS);
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int SW  = COUNT_W + 2 * QW;
    localparam int WAW = IW + QW;
    localparam int WDEPTH = 1 << WAW;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
    localparam logic [QW-1:0] LAST_PTR  = QW'(QUEUE_DEPTH - 1);

    state_t state_reg, state_next;

    logic [1:0]        func_reg,      func_next;
    logic [NAME_W-1:0] name_reg,      name_next;
    logic [14:0]       init_reg,      init_next;
    logic [IW-1:0]     hslot_reg,     hslot_next;
    logic [5:0]        task_reg,      task_next;
    logic [IW-1:0]     scan_idx_reg,  scan_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]     cmp_idx_reg,   cmp_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IW-1:0]     free_idx_reg,  free_idx_next;
    logic [SLOTS-1:0]  used_reg,      used_next;

    logic [2:0] res_status_reg, res_status_next;
    logic [4:0] res_handle_reg, res_handle_next;
    logic       res_block_reg,  res_block_next;
    logic       res_wv_reg,     res_wv_next;
    logic [5:0] res_wt_reg,     res_wt_next;

    logic       out_valid_reg,  out_valid_next;
    logic [2:0] out_status_reg, out_status_next;
    logic [4:0] out_handle_reg, out_handle_next;
    logic       out_block_reg,  out_block_next;
    logic       out_wv_reg,     out_wv_next;
    logic [5:0] out_wt_reg,     out_wt_next;

    logic [NAME_W-1:0] name_canon;
    logic              too_long;

    logic              name_we;
    logic [IW-1:0]     name_waddr;
    logic [IW-1:0]     name_raddr;
    logic [NAME_W-1:0] name_rdata;

    logic              st_we;
    logic [IW-1:0]     st_raddr;
    logic [SW-1:0]     st_wdata;
    logic [SW-1:0]     st_rdata;

    logic              wq_we;
    logic [WAW-1:0]    wq_waddr;
    logic [WAW-1:0]    wq_raddr;
    logic [5:0]        wq_rdata;

    logic accept;
    logic out_free;
    logic handle_ok;
    logic is_name_op;

    logic          match;
    logic          last;
    logic          conclude;
    logic          free_here;
    logic          free_any;
    logic [IW-1:0] free_sel;
    logic          do_create;

    logic signed [COUNT_W-1:0] cnt;
    logic signed [COUNT_W-1:0] cnt_dec;
    logic signed [COUNT_W-1:0] cnt_inc;
    logic [QW-1:0] head;
    logic [QW-1:0] tail;
    logic [QW-1:0] tail_nx;
    logic [QW-1:0] head_nx;
    logic          q_full;
    logic          q_empty;
    logic          wait_blocks;
    logic          post_wakes;
    logic          deq;

    nst_canon u_canon (
        .name_low   (req.name_low),
        .name_high  (req.name_high),
        .name_canon (name_canon),
        .too_long   (too_long)
    );

    nst_ram #(.WIDTH(NAME_W), .DEPTH(SLOTS)) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (name_reg),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    nst_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (name_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    nst_ram #(.WIDTH(6), .DEPTH(WDEPTH)) u_wait_ram (
        .clk   (clk),
        .we    (wq_we),
        .waddr (wq_waddr),
        .wdata (task_reg),
        .raddr (wq_raddr),
        .rdata (wq_rdata)
    );

    assign accept     = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign is_name_op = (req.func == FN_OPEN) || (req.func == FN_UNLINK);
    assign handle_ok  = (32'(req.sem_handle) < SLOTS) && used_reg[IW'(req.sem_handle)];

    assign match     = cmp_valid_reg && used_reg[cmp_idx_reg] && (name_rdata == name_reg);
    assign last      = cmp_valid_reg && (cmp_idx_reg == LAST_SLOT);
    assign conclude  = match || last;
    assign free_here = cmp_valid_reg && !used_reg[cmp_idx_reg];
    assign free_any  = free_found_reg || free_here;
    assign free_sel  = free_found_reg ? free_idx_reg : cmp_idx_reg;
    assign do_create = (state_reg == S_SCAN) && conclude && !match &&
                       (func_reg == FN_OPEN) && free_any;

    assign cnt     = st_rdata[SW-1 -: COUNT_W];
    assign head    = st_rdata[2*QW-1 -: QW];
    assign tail    = st_rdata[QW-1:0];
    assign cnt_dec = (cnt != COUNT_MIN) ? cnt - 16'sd1 : cnt;
    assign cnt_inc = (cnt != COUNT_MAX) ? cnt + 16'sd1 : cnt;
    assign tail_nx = (tail == LAST_PTR) ? '0 : tail + 1'b1;
    assign head_nx = (head == LAST_PTR) ? '0 : head + 1'b1;
    assign q_full  = (tail_nx == head);
    assign q_empty = (head == tail);
    assign wait_blocks = cnt_dec[COUNT_W-1];
    assign post_wakes  = cnt_inc[COUNT_W-1] || (cnt_inc == '0);
    assign deq = (func_reg == FN_POST) && post_wakes && !q_empty;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (is_name_op)
                    begin
                        state_next = too_long ? S_DONE : S_SCAN;
                    end
                    else
                    begin
                        state_next = handle_ok ? S_RD : S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (conclude)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = deq ? S_WAKE : S_DONE;
            end
            S_WAKE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory and handshake controls
    always_comb
    begin
        req.ready  = (state_reg == S_IDLE);
        name_raddr = scan_idx_reg;
        name_waddr = (state_reg == S_SCAN) ? free_sel : hslot_reg;
        name_we    = do_create;
        st_raddr   = hslot_reg;
        st_we      = 1'b0;
        st_wdata   = {cnt_dec, head, tail};
        wq_we      = 1'b0;
        wq_waddr   = {hslot_reg, tail};
        wq_raddr   = {hslot_reg, head};
        unique case (state_reg)
            S_SCAN:
            begin
                st_we    = do_create;
                st_wdata = {COUNT_W'(init_reg), {QW{1'b0}}, {QW{1'b0}}};
            end
            S_EXEC:
            begin
                if (func_reg == FN_WAIT)
                begin
                    if (!wait_blocks)
                    begin
                        st_we    = 1'b1;
                        st_wdata = {cnt_dec, head, tail};
                    end
                    else if (!q_full)
                    begin
                        st_we    = 1'b1;
                        st_wdata = {cnt_dec, head, tail_nx};
                        wq_we    = 1'b1;
                    end
                end
                else
                begin
                    st_we    = 1'b1;
                    st_wdata = {cnt_inc, deq ? head_nx : head, tail};
                end
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        func_next       = func_reg;
        name_next       = name_reg;
        init_next       = init_reg;
        hslot_next      = hslot_reg;
        task_next       = task_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_block_next  = res_block_reg;
        res_wv_next     = res_wv_reg;
        res_wt_next     = res_wt_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        out_block_next  = out_block_reg;
        out_wv_next     = out_wv_reg;
        out_wt_next     = out_wt_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next       = req.func;
                    name_next       = name_canon;
                    init_next       = req.init_value;
                    hslot_next      = IW'(req.sem_handle);
                    task_next       = req.task_id;
                    scan_idx_next   = '0;
                    cmp_valid_next  = 1'b0;
                    free_found_next = 1'b0;
                    res_status_next = ST_OK;
                    res_handle_next = '0;
                    res_block_next  = 1'b0;
                    res_wv_next     = 1'b0;
                    res_wt_next     = '0;
                    if (is_name_op && too_long)
                    begin
                        res_status_next = ST_TOO_LONG;
                    end
                    else if (!is_name_op && !handle_ok)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_SCAN:
            begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_idx_reg;
                scan_idx_next  = scan_idx_reg + 1'b1;
                if (free_here && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (conclude)
                begin
                    if (func_reg == FN_OPEN)
                    begin
                        if (match)
                        begin
                            res_handle_next = 5'(cmp_idx_reg);
                        end
                        else if (free_any)
                        begin
                            res_handle_next     = 5'(free_sel);
                            used_next[free_sel] = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_TABLE_FULL;
                        end
                    end
                    else
                    begin
                        if (match)
                        begin
                            used_next[cmp_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_EXEC:
            begin
                if (func_reg == FN_WAIT)
                begin
                    if (wait_blocks)
                    begin
                        if (q_full)
                        begin
                            res_status_next = ST_QUEUE_FULL;
                        end
                        else
                        begin
                            res_block_next = 1'b1;
                        end
                    end
                end
                else if (post_wakes && q_empty)
                begin
                    res_status_next = ST_QUEUE_EMPTY;
                end
            end
            S_WAKE:
            begin
                res_wv_next = 1'b1;
                res_wt_next = wq_rdata;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_block_next  = res_block_reg;
                    out_wv_next     = res_wv_reg;
                    out_wt_next     = res_wt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        name_reg       <= name_next;
        init_reg       <= init_next;
        hslot_reg      <= hslot_next;
        task_reg       <= task_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_block_reg  <= res_block_next;
        res_wv_reg     <= res_wv_next;
        res_wt_reg     <= res_wt_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_block_reg  <= out_block_next;
        out_wv_reg     <= out_wv_next;
        out_wt_reg     <= out_wt_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.handle_out  = out_handle_reg;
    assign rsp.must_block  = out_block_reg;
    assign rsp.woken_valid = out_wv_reg;
    assign rsp.woken_task  = out_wt_reg;

endmodule
`default_nettype wire

// ===== dv/named_semaphore_table_tb.sv =====
`timescale 1ns / 1ps
module named_semaphore_table_tb;
    import nst_pkg::*;

    localparam int SLOTS       = 32;
    localparam int QDEPTH      = 16;
    localparam int POOL        = 48;
    localparam int PHASE_OPS   = 200;
    localparam int DRAIN       = 60;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [14:0] init;
        logic [4:0]  handle;
        logic [5:0]  task_id;
    } sem_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] handle;
        logic       must_block;
        logic       woken_valid;
        logic [5:0] woken_task;
    } sem_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    nst_req_if req_bus();
    nst_rsp_if rsp_bus();

    named_semaphore_table #(
        .SLOTS       (SLOTS),
        .QUEUE_DEPTH (QDEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // semaphore table shadow
    logic [127:0]              slot_name [SLOTS];
    bit                        slot_busy [SLOTS];
    logic signed [COUNT_W-1:0] slot_cnt  [SLOTS];
    logic [5:0]                waiters   [SLOTS][QDEPTH];
    logic [3:0]                q_head    [SLOTS];
    logic [3:0]                q_tail    [SLOTS];

    sem_req_t pending_ops[$];
    sem_rsp_t due_replies[$];
    sem_req_t next_op;
    sem_rsp_t want;

    logic [127:0] name_pool [POOL];
    int           name_len  [POOL];

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int fail_count   = 0;
    int cycles       = 0;

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            slot_name[s] = '0;
            slot_busy[s] = 1'b0;
            slot_cnt[s]  = '0;
            q_head[s]    = '0;
            q_tail[s]    = '0;
        end
    end

    // name ends at first NUL; trailing bytes are zeroed
    function automatic bit canon_name(input logic [127:0] raw, output logic [127:0] key);
        bit ended;
        ended = 1'b0;
        key   = raw;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (ended)
                key[8*b +: 8] = 8'h00;
            else if (key[8*b +: 8] == 8'h00)
                ended = 1'b1;
        end
        return ended;
    endfunction

    function automatic sem_rsp_t apply_sem_op(sem_req_t op);
        sem_rsp_t                  r;
        logic [127:0]              key;
        logic signed [COUNT_W-1:0] c;
        logic signed [COUNT_W-1:0] nc;
        logic [3:0]                nt;
        int                        hit;
        int                        h;
        r = '0;
        h = op.handle;
        if (op.func == FN_OPEN || op.func == FN_UNLINK)
        begin
            if (!canon_name({op.hi, op.lo}, key))
                r.status = ST_TOO_LONG;
            else
            begin
                hit = -1;
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && slot_busy[s] && slot_name[s] == key)
                        hit = s;
                if (op.func == FN_OPEN)
                begin
                    if (hit < 0)
                    begin
                        for (int s = 0; s < SLOTS; s++)
                            if (hit < 0 && !slot_busy[s])
                                hit = s;
                        if (hit < 0)
                            r.status = ST_TABLE_FULL;
                        else
                        begin
                            slot_busy[hit] = 1'b1;
                            slot_name[hit] = key;
                            slot_cnt[hit]  = {1'b0, op.init};
                            q_head[hit]    = '0;
                            q_tail[hit]    = '0;
                        end
                    end
                    if (hit >= 0)
                        r.handle = 5'(hit);
                end
                else if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    slot_busy[hit] = 1'b0;
                    slot_name[hit] = '0;
                    slot_cnt[hit]  = '0;
                end
            end
        end
        else if (h >= SLOTS || !slot_busy[h])
            r.status = ST_NOT_FOUND;
        else if (op.func == FN_WAIT)
        begin
            c  = slot_cnt[h];
            nc = (c != COUNT_MIN) ? c - 16'sd1 : c;
            if (nc < 0)
            begin
                nt = q_tail[h] + 4'd1;
                if (nt == q_head[h])
                    r.status = ST_QUEUE_FULL;
                else
                begin
                    waiters[h][q_tail[h]] = op.task_id;
                    q_tail[h]    = nt;
                    slot_cnt[h]  = nc;
                    r.must_block = 1'b1;
                end
            end
            else
                slot_cnt[h] = nc;
        end
        else
        begin
            c  = slot_cnt[h];
            nc = (c != COUNT_MAX) ? c + 16'sd1 : c;
            slot_cnt[h] = nc;
            if (nc <= 0)
            begin
                if (q_head[h] == q_tail[h])
                    r.status = ST_QUEUE_EMPTY;
                else
                begin
                    r.woken_task  = waiters[h][q_head[h]];
                    r.woken_valid = 1'b1;
                    q_head[h]     = q_head[h] + 4'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic sem_req_t random_op();
        sem_req_t op;
        op.func    = 2'($urandom_range(0, 3));
        op.lo      = {$urandom, $urandom};
        op.hi      = {$urandom, $urandom};
        op.init    = 15'($urandom_range(0, 32767));
        op.handle  = 5'($urandom_range(0, 31));
        op.task_id = 6'($urandom_range(0, 63));
        return op;
    endfunction

    function automatic sem_req_t named_op(logic [1:0] func, int idx);
        sem_req_t     op;
        logic [127:0] n;
        op = random_op();
        n  = name_pool[idx];
        if (name_len[idx] < 15 && $urandom_range(0, 1))
            for (int b = name_len[idx] + 1; b < NAME_BYTES; b++)
                n[8*b +: 8] = 8'($urandom_range(0, 255));
        op.func = func;
        {op.hi, op.lo} = n;
        if ($urandom_range(0, 9) < 7)
            op.init = 15'($urandom_range(0, 3));
        return op;
    endfunction

    function automatic sem_req_t handle_op(logic [1:0] func, int h);
        sem_req_t op;
        op        = random_op();
        op.func   = func;
        op.handle = 5'(h);
        return op;
    endfunction

    function automatic int pick_handle();
        return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
    endfunction

    function automatic sem_req_t fixed_op(logic [1:0] func, logic [63:0] lo, logic [63:0] hi,
                                          logic [14:0] init, logic [4:0] handle,
                                          logic [5:0] task_id);
        sem_req_t op;
        op         = random_op();
        op.func    = func;
        op.lo      = lo;
        op.hi      = hi;
        op.init    = init;
        if (func == FN_WAIT || func == FN_POST)
            op.handle = handle;
        op.task_id = task_id;
        return op;
    endfunction

    task automatic add_random_ops(int count);
        int made;
        int roll;
        int h;
        int k;
        made = 0;
        while (made < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                pending_ops.push_back(named_op(FN_OPEN, $urandom_range(0, POOL - 1)));
            else if (roll < 52)
                pending_ops.push_back(handle_op(FN_WAIT, pick_handle()));
            else if (roll < 79)
                pending_ops.push_back(handle_op(FN_POST, pick_handle()));
            else if (roll < 87)
                pending_ops.push_back(named_op(FN_UNLINK, $urandom_range(0, POOL - 1)));
            else if (roll < 93)
            begin
                h = pick_handle();
                k = $urandom_range(8, 18);
                for (int i = 0; i < k; i++)
                    pending_ops.push_back(handle_op(FN_WAIT, h));
                for (int i = 0; i < k; i++)
                    pending_ops.push_back(handle_op(FN_POST, h));
                made += 2 * k - 1;
            end
            else
                pending_ops.push_back(random_op());
            made++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                due_replies.push_back(apply_sem_op({req_bus.func, req_bus.name_low,
                                                    req_bus.name_high, req_bus.init_value,
                                                    req_bus.sem_handle, req_bus.task_id}));
            if (!req_bus.valid || req_bus.ready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    next_op            = pending_ops.pop_front();
                    req_bus.valid      <= 1'b1;
                    req_bus.func       <= next_op.func;
                    req_bus.name_low   <= next_op.lo;
                    req_bus.name_high  <= next_op.hi;
                    req_bus.init_value <= next_op.init;
                    req_bus.sem_handle <= next_op.handle;
                    req_bus.task_id    <= next_op.task_id;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (due_replies.size() == 0)
                begin
                    $error("response beat with nothing expected, status %0d", rsp_bus.status);
                    fail_count++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (rsp_bus.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                        fail_count++;
                    end
                    if (rsp_bus.handle_out !== want.handle)
                    begin
                        $error("handle_out: expected %0d, got %0d", want.handle,
                               rsp_bus.handle_out);
                        fail_count++;
                    end
                    if (rsp_bus.must_block !== want.must_block)
                    begin
                        $error("must_block: expected %0d, got %0d", want.must_block,
                               rsp_bus.must_block);
                        fail_count++;
                    end
                    if (rsp_bus.woken_valid !== want.woken_valid)
                    begin
                        $error("woken_valid: expected %0d, got %0d", want.woken_valid,
                               rsp_bus.woken_valid);
                        fail_count++;
                    end
                    if (rsp_bus.woken_task !== want.woken_task)
                    begin
                        $error("woken_task: expected %0d, got %0d", want.woken_task,
                               rsp_bus.woken_task);
                        fail_count++;
                    end
                end
            end
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.func       = FN_OPEN;
        req_bus.name_low   = '0;
        req_bus.name_high  = '0;
        req_bus.init_value = '0;
        req_bus.sem_handle = '0;
        req_bus.task_id    = '0;
        rsp_bus.ready      = 1'b0;

        for (int i = 0; i < POOL; i++)
        begin
            name_len[i]  = (i < 2) ? 15 * i : $urandom_range(0, 15);
            name_pool[i] = '0;
            for (int b = 0; b < name_len[i]; b++)
                name_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
        end

        // directed
        pending_ops.push_back(fixed_op(FN_OPEN, 64'h41, 64'h0, 15'd0, 5'd0, 6'd1));
        pending_ops.push_back(fixed_op(FN_OPEN, 64'h0, 64'hDEAD_BEEF_0123_4567, 15'd5,
                                       5'd0, 6'd2));
        pending_ops.push_back(fixed_op(FN_OPEN, 64'hFFFF_FFFF_FF00_0041, 64'hFFFF, 15'd9,
                                       5'd0, 6'd3));
        pending_ops.push_back(fixed_op(FN_OPEN, '1, '1, 15'd1, 5'd0, 6'd4));
        pending_ops.push_back(fixed_op(FN_UNLINK, '1, '1, 15'd1, 5'd0, 6'd5));
        pending_ops.push_back(fixed_op(FN_OPEN, '1, 64'h00FF_FFFF_FFFF_FFFF, 15'h7FFF,
                                       5'd0, 6'd6));
        pending_ops.push_back(fixed_op(FN_OPEN, 64'h42, 64'h0, 15'd1, 5'd0, 6'd7));
        pending_ops.push_back(fixed_op(FN_WAIT, '0, '0, 15'd0, 5'd0, 6'd63));
        pending_ops.push_back(fixed_op(FN_WAIT, '0, '0, 15'd0, 5'd0, 6'd0));
        pending_ops.push_back(fixed_op(FN_POST, '0, '0, 15'd0, 5'd0, 6'd0));
        pending_ops.push_back(fixed_op(FN_POST, '0, '0, 15'd0, 5'd0, 6'd0));
        pending_ops.push_back(fixed_op(FN_POST, '0, '0, 15'd0, 5'd0, 6'd0));
        pending_ops.push_back(fixed_op(FN_POST, '0, '0, 15'd0, 5'd2, 6'd0));
        pending_ops.push_back(fixed_op(FN_WAIT, '0, '0, 15'd0, 5'd3, 6'd5));
        pending_ops.push_back(fixed_op(FN_WAIT, '0, '0, 15'd0, 5'd31, 6'd5));
        pending_ops.push_back(fixed_op(FN_POST, '0, '0, 15'd0, 5'd31, 6'd5));
        pending_ops.push_back(fixed_op(FN_UNLINK, 64'h42, 64'h0, 15'd0, 5'd0, 6'd0));
        pending_ops.push_back(fixed_op(FN_UNLINK, 64'h42, 64'h0, 15'd0, 5'd0, 6'd0));
        pending_ops.push_back(fixed_op(FN_POST, '0, '0, 15'd0, 5'd3, 6'd0));
        pending_ops.push_back(fixed_op(FN_UNLINK, 64'h0, 64'h1234, 15'd0, 5'd0, 6'd0));
        pending_ops.push_back(fixed_op(FN_OPEN, 64'h43, 64'h0, 15'd2, 5'd0, 6'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            send_gap_pct = (ph == 1) ? 53 : (ph == 3) ? 8 : 0;
            stall_pct    = (ph == 2) ? 53 : (ph == 3) ? 8 : 0;
            add_random_ops(PHASE_OPS);
            while (pending_ops.size() != 0)
                @(negedge clk);
        end

        while (pending_ops.size() != 0 || req_bus.valid || due_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);

        if (fail_count == 0 && due_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
